/* src/htld_pkg.sv */
package htld_pkg;

    localparam int NODE_CAPACITY   = 512;
    localparam int MAX_CODE_LENGTH = 128;

    localparam int NODE_W    = $clog2(NODE_CAPACITY);
    localparam int FREE_W    = $clog2(NODE_CAPACITY + 1);
    localparam int STK_IDX_W = $clog2(MAX_CODE_LENGTH);
    localparam int CNT_W     = $clog2(MAX_CODE_LENGTH + 1);
    localparam int SYM_W     = 8;

    typedef logic [1:0] status_t;

    localparam status_t ST_SYMBOL    = 2'd0;
    localparam status_t ST_TREE_DONE = 2'd1;
    localparam status_t ST_BAD_PATH  = 2'd2;
    localparam status_t ST_OVERFLOW  = 2'd3;

    localparam logic REQ_TOKEN = 1'b0;
    localparam logic REQ_BIT   = 1'b1;

    // Each internal node keeps what the walk needs about both children.
    // Left child index is always parent + 1 in pre-order, so it is not stored.
    typedef struct packed {
        logic              l_leaf;
        logic [SYM_W-1:0]  l_sym;
        logic [NODE_W-1:0] r_idx;
        logic              r_leaf;
        logic [SYM_W-1:0]  r_sym;
    } node_entry_t;

    localparam int L_PART_W = SYM_W + 1;
    localparam int R_PART_W = NODE_W + SYM_W + 1;
    localparam int ENTRY_W  = L_PART_W + R_PART_W;

    localparam logic [ENTRY_W-1:0] LEFT_MASK  = {{L_PART_W{1'b1}}, {R_PART_W{1'b0}}};
    localparam logic [ENTRY_W-1:0] RIGHT_MASK = {{L_PART_W{1'b0}}, {R_PART_W{1'b1}}};

endpackage

/* src/huffman_tree_load_and_decode.sv */
// A request that produces a result has it in the output register in the cycle after it is accepted.
// Throughput: 1 request per cycle, tree tokens and code bits alike, unless a stalled
//   result holds the input; the node table read for the current cursor is issued in
//   the cycle before, so each bit needs one read whose data forms the next read address.
// Reset (rst_n, async, active low): no tree, cursor at root, stack empty, output empty.
//   Node table and stack contents are not cleared; only entries written by a load are read.
module huffman_tree_load_and_decode
    import htld_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             req_type,
    input  logic             tree_start,
    input  logic             token_leaf,
    input  logic [SYM_W-1:0] token_symbol,
    input  logic             code_bit,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [SYM_W-1:0] symbol,
    output logic [1:0]       status
);

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]  stack_count_reg, stack_count_next;
    logic [NODE_W-1:0] attach_node_reg, attach_node_next;
    logic              attach_right_reg, attach_right_next;
    logic [FREE_W-1:0] free_index_reg, free_index_next;
    logic [NODE_W-1:0] cursor_reg, cursor_next;
    logic              tree_ready_reg, tree_ready_next;
    logic              load_closed_reg, load_closed_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]  symbol_reg;
    status_t           status_reg;

    // result of the request being accepted this cycle
    logic              res_valid;
    logic [SYM_W-1:0]  res_symbol;
    status_t           res_status;

    logic              in_acc;

    // ------------------------------------------------------------------
    // Memories and forwarding
    // ------------------------------------------------------------------
    logic                 node_wr_en;
    logic [NODE_W-1:0]    node_wr_addr;
    logic [ENTRY_W-1:0]   node_wr_data;
    logic [ENTRY_W-1:0]   node_wr_mask;
    logic [ENTRY_W-1:0]   node_q;
    logic [ENTRY_W-1:0]   node_fwd_mask_reg;
    logic [ENTRY_W-1:0]   node_fwd_data_reg;
    node_entry_t          node_rd;
    node_entry_t          wr_entry;

    logic                 stk_wr_en;
    logic [STK_IDX_W-1:0] stk_wr_addr;
    logic [NODE_W-1:0]    stk_wr_data;
    logic [STK_IDX_W-1:0] stk_rd_addr;
    logic [NODE_W-1:0]    stk_q;
    logic                 stk_fwd_reg;
    logic [NODE_W-1:0]    stk_fwd_data_reg;
    logic [NODE_W-1:0]    stk_top;

    // ------------------------------------------------------------------
    // Load-side view after an optional tree_start clear
    // ------------------------------------------------------------------
    logic              closed_eff;
    logic [FREE_W-1:0] free_eff;
    logic [CNT_W-1:0]  count_eff;
    logic [NODE_W-1:0] attach_node_eff;
    logic              attach_right_eff;
    logic [NODE_W-1:0] new_node;
    logic              overflow;

    // one walk step from the cursor
    logic [NODE_W-1:0] step_idx;
    logic              step_leaf;
    logic [SYM_W-1:0]  step_sym;
    logic              step_missing;

    // Input is held only while a finished result waits downstream.
    assign in_stall = out_valid_reg && out_stall;
    assign in_acc   = in_valid && !in_stall;

    assign closed_eff       = tree_start ? 1'b0 : load_closed_reg;
    assign free_eff         = tree_start ? '0 : free_index_reg;
    assign count_eff        = tree_start ? '0 : stack_count_reg;
    assign attach_node_eff  = tree_start ? '0 : attach_node_reg;
    assign attach_right_eff = tree_start ? 1'b0 : attach_right_reg;
    assign new_node         = free_eff[NODE_W-1:0];
    assign overflow         = (free_eff >= FREE_W'(NODE_CAPACITY))
                            || (!token_leaf && (count_eff >= CNT_W'(MAX_CODE_LENGTH)));

    // RAM read returns old data on a same-cycle write to its address; merge the captured write.
    assign node_rd = node_entry_t'((node_q & ~node_fwd_mask_reg)
                                 | (node_fwd_data_reg & node_fwd_mask_reg));
    assign stk_top = stk_fwd_reg ? stk_fwd_data_reg : stk_q;

    // 1 goes right (stored index), 0 goes left (always cursor + 1)
    assign step_idx     = code_bit ? node_rd.r_idx : cursor_reg + NODE_W'(1);
    assign step_leaf    = code_bit ? node_rd.r_leaf : node_rd.l_leaf;
    assign step_sym     = code_bit ? node_rd.r_sym : node_rd.l_sym;
    assign step_missing = code_bit && (node_rd.r_idx == '0);

    always_comb
    begin
        stack_count_next  = stack_count_reg;
        attach_node_next  = attach_node_reg;
        attach_right_next = attach_right_reg;
        free_index_next   = free_index_reg;
        cursor_next       = cursor_reg;
        tree_ready_next   = tree_ready_reg;
        load_closed_next  = load_closed_reg;

        res_valid  = 1'b0;
        res_symbol = '0;
        res_status = ST_SYMBOL;

        wr_entry     = '0;
        node_wr_en   = 1'b0;
        node_wr_addr = attach_node_eff;
        node_wr_mask = LEFT_MASK;
        stk_wr_en    = 1'b0;
        stk_wr_addr  = count_eff[STK_IDX_W-1:0];
        stk_wr_data  = new_node;

        if (in_acc)
        begin
            if (req_type == REQ_BIT)
            begin
                if (!tree_ready_reg)
                begin
                    res_valid  = 1'b1;
                    res_status = ST_BAD_PATH;
                end
                else if (step_missing)
                begin
                    res_valid   = 1'b1;
                    res_status  = ST_BAD_PATH;
                    cursor_next = '0;
                end
                else if (step_leaf)
                begin
                    res_valid   = 1'b1;
                    res_status  = ST_SYMBOL;
                    res_symbol  = step_sym;
                    cursor_next = '0;
                end
                else
                begin
                    cursor_next = step_idx;
                end
            end
            else
            begin
                if (tree_start)
                begin
                    stack_count_next  = '0;
                    attach_node_next  = '0;
                    attach_right_next = 1'b0;
                    free_index_next   = '0;
                    cursor_next       = '0;
                    tree_ready_next   = 1'b0;
                    load_closed_next  = 1'b0;
                end

                if (closed_eff)
                begin
                    res_valid  = 1'b1;
                    res_status = ST_BAD_PATH;
                end
                else if (overflow)
                begin
                    load_closed_next = 1'b1;
                    tree_ready_next  = 1'b0;
                    res_valid        = 1'b1;
                    res_status       = ST_OVERFLOW;
                end
                else
                begin
                    // hook the new node into its parent's left or right half
                    if (new_node != '0)
                    begin
                        node_wr_en = 1'b1;
                        if (attach_right_eff)
                        begin
                            wr_entry.r_idx  = new_node;
                            wr_entry.r_leaf = token_leaf;
                            wr_entry.r_sym  = token_symbol;
                            node_wr_mask    = RIGHT_MASK;
                        end
                        else
                        begin
                            wr_entry.l_leaf = token_leaf;
                            wr_entry.l_sym  = token_symbol;
                            node_wr_mask    = LEFT_MASK;
                        end
                    end
                    free_index_next = free_eff + FREE_W'(1);

                    if (!token_leaf)
                    begin
                        stk_wr_en         = 1'b1;
                        stack_count_next  = count_eff + CNT_W'(1);
                        attach_node_next  = new_node;
                        attach_right_next = 1'b0;
                    end
                    else if (count_eff != '0)
                    begin
                        stack_count_next  = count_eff - CNT_W'(1);
                        attach_node_next  = stk_top;
                        attach_right_next = 1'b1;
                    end
                    else
                    begin
                        // last leaf: tree closed; a lone leaf has no code paths
                        load_closed_next = 1'b1;
                        cursor_next      = '0;
                        res_valid        = 1'b1;
                        if (new_node == '0)
                        begin
                            tree_ready_next = 1'b0;
                            res_status      = ST_BAD_PATH;
                        end
                        else
                        begin
                            tree_ready_next = 1'b1;
                            res_status      = ST_TREE_DONE;
                        end
                    end
                end
            end
        end
    end

    assign node_wr_data = ENTRY_W'(wr_entry);

    // top of stack is read ahead for the state after this edge
    assign stk_rd_addr = STK_IDX_W'(stack_count_next - CNT_W'(1));

    always_comb
    begin
        if (in_acc)
        begin
            out_valid_next = res_valid;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_count_reg   <= '0;
            attach_node_reg   <= '0;
            attach_right_reg  <= 1'b0;
            free_index_reg    <= '0;
            cursor_reg        <= '0;
            tree_ready_reg    <= 1'b0;
            load_closed_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
            node_fwd_mask_reg <= '0;
            stk_fwd_reg       <= 1'b0;
        end
        else
        begin
            stack_count_reg   <= stack_count_next;
            attach_node_reg   <= attach_node_next;
            attach_right_reg  <= attach_right_next;
            free_index_reg    <= free_index_next;
            cursor_reg        <= cursor_next;
            tree_ready_reg    <= tree_ready_next;
            load_closed_reg   <= load_closed_next;
            out_valid_reg     <= out_valid_next;
            node_fwd_mask_reg <= (node_wr_en && (node_wr_addr == cursor_next))
                               ? node_wr_mask : '0;
            stk_fwd_reg       <= stk_wr_en && (stk_wr_addr == stk_rd_addr);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        node_fwd_data_reg <= node_wr_data;
        stk_fwd_data_reg  <= stk_wr_data;
        if (in_acc && res_valid)
        begin
            symbol_reg <= res_symbol;
            status_reg <= res_status;
        end
    end

    // node table: read address is the cursor for the next cycle
    htld_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NODE_CAPACITY)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (node_wr_en),
        .wr_addr (node_wr_addr),
        .wr_data (node_wr_data),
        .wr_mask (node_wr_mask),
        .rd_addr (cursor_next),
        .rd_data (node_q)
    );

    // pending stack of internal nodes still owed a right child
    htld_ram #(
        .WIDTH (NODE_W),
        .DEPTH (MAX_CODE_LENGTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .wr_mask ({NODE_W{1'b1}}),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_q)
    );

    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;
    assign status    = status_reg;

endmodule

/* src/htld_ram.sv */
module htld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [WIDTH-1:0]         wr_mask,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // bit-enable write, read returns old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int i = 0; i < WIDTH; i++)
            begin
                if (wr_mask[i])
                begin
                    mem[wr_addr][i] <= wr_data[i];
                end
            end
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/htld_checker.sv */
module htld_checker
    import htld_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             req_type,
    input logic             tree_start,
    input logic             token_leaf,
    input logic             out_valid,
    input logic             out_stall,
    input logic [SYM_W-1:0] symbol,
    input logic [1:0]       status
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(symbol) && $stable(status))
        else $error("stalled result changed");

    // input only backs up behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    // only decoded symbols carry a symbol byte
    a_sym_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_SYMBOL) |-> symbol == '0)
        else $error("nonzero symbol on status result");

    // a tree that starts with a leaf is a lone leaf and fails
    a_lone_leaf: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type == REQ_TOKEN) && tree_start && token_leaf
        |=> out_valid && (status == ST_BAD_PATH))
        else $error("single-leaf tree not flagged");

    // tokens never produce a decoded symbol
    a_token_no_sym: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type == REQ_TOKEN)
        |=> !(out_valid && (status == ST_SYMBOL)))
        else $error("symbol result from tree token");

endmodule

bind huffman_tree_load_and_decode htld_checker u_htld_checker (.*);
